// ===== src/segment_plane_clip_assert.svh =====
// Assertion macros for the segment plane clipper.
`ifndef SEGMENT_PLANE_CLIP_ASSERT_SVH
`define SEGMENT_PLANE_CLIP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SPC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SPC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/spc_pkg.sv =====
// Shared constants, types and helpers for the segment plane clipper.
package spc_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_BITS   = FRAC_BITS + 1;
    localparam int NUM_REGS   = 7;
    localparam int IDX_BITS   = 3;

    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int PROD_W  = 2 * COORD_BITS;
    localparam int DOT_W   = PROD_W - FRAC_BITS + 2;
    localparam int REM_W   = DOT_W + 1;
    localparam int Q_W     = FRAC_BITS + 1;
    localparam int TPROD_W = Q_W + 1 + DIFF_W;

    // register indexes
    localparam logic [IDX_BITS-1:0] REG_POINT_X  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_POINT_Y  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_POINT_Z  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_NORMAL_X = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_NORMAL_Y = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_NORMAL_Z = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_TOL      = 3'd6;

    // case codes
    localparam logic [1:0] CASE_COINCIDENT = 2'd0;
    localparam logic [1:0] CASE_PARALLEL   = 2'd1;
    localparam logic [1:0] CASE_OUTSIDE    = 2'd2;
    localparam logic [1:0] CASE_CUT        = 2'd3;

    typedef logic [2:0][COORD_BITS-1:0] vec3_t;

    typedef struct packed {
        vec3_t                point;
        vec3_t                normal;
        logic [TOL_BITS-1:0]  tol;
    } plane_t;

    typedef struct packed {
        vec3_t       s;
        vec3_t       e;
        logic [1:0]  code;
        logic        trimmed;
        logic        whole;
        logic        from_start;
    } seg_info_t;

    // exact difference a - b of two signed coordinates
    function automatic logic [DIFF_W-1:0] coord_diff(logic [COORD_BITS-1:0] a,
                                                     logic [COORD_BITS-1:0] b);
        coord_diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    endfunction

    // clamp a difference to the signed coordinate range
    function automatic logic [COORD_BITS-1:0] sat_coord(logic [DIFF_W-1:0] x);
        if (x[DIFF_W-1] != x[DIFF_W-2])
            sat_coord = x[DIFF_W-1] ? {1'b1, {(COORD_BITS-1){1'b0}}}
                                    : {1'b0, {(COORD_BITS-1){1'b1}}};
        else
            sat_coord = x[COORD_BITS-1:0];
    endfunction

endpackage

// ===== src/spc_ifs.sv =====
// Handshake interfaces for segment words, result words and register writes.
interface spc_seg_in_if;
    logic valid;
    logic ready;
    logic signed [spc_pkg::COORD_BITS-1:0] start_x;
    logic signed [spc_pkg::COORD_BITS-1:0] start_y;
    logic signed [spc_pkg::COORD_BITS-1:0] start_z;
    logic signed [spc_pkg::COORD_BITS-1:0] end_x;
    logic signed [spc_pkg::COORD_BITS-1:0] end_y;
    logic signed [spc_pkg::COORD_BITS-1:0] end_z;
    modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                    input ready);
    modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
    modport monitor (input valid, ready, start_x, start_y, start_z, end_x, end_y, end_z);
endinterface

interface spc_seg_out_if;
    logic valid;
    logic ready;
    logic signed [spc_pkg::COORD_BITS-1:0] kept_start_x;
    logic signed [spc_pkg::COORD_BITS-1:0] kept_start_y;
    logic signed [spc_pkg::COORD_BITS-1:0] kept_start_z;
    logic signed [spc_pkg::COORD_BITS-1:0] kept_end_x;
    logic signed [spc_pkg::COORD_BITS-1:0] kept_end_y;
    logic signed [spc_pkg::COORD_BITS-1:0] kept_end_z;
    logic        fully_trimmed;
    logic [1:0]  case_code;
    modport source (output valid, kept_start_x, kept_start_y, kept_start_z,
                    kept_end_x, kept_end_y, kept_end_z, fully_trimmed, case_code,
                    input ready);
    modport sink (input valid, kept_start_x, kept_start_y, kept_start_z,
                  kept_end_x, kept_end_y, kept_end_z, fully_trimmed, case_code,
                  output ready);
    modport monitor (input valid, ready, kept_start_x, kept_start_y, kept_start_z,
                     kept_end_x, kept_end_y, kept_end_z, fully_trimmed, case_code);
endinterface

interface spc_cfg_if;
    logic valid;
    logic ready;
    logic [spc_pkg::IDX_BITS-1:0]   index;
    logic [spc_pkg::COORD_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
    modport monitor (input valid, ready, index, data);
endinterface

// ===== src/segment_plane_clip.sv =====
// Top level of the segment plane clipper: registers, pipeline and result port.
// Clips each 3D Q16.16 segment word against the configured half space and
// returns the kept piece, a fully-trimmed flag and a case code. The pipeline
// takes one segment word every cycle while the result port is not stalled and
// passes it through four stages of offset, dot product and case decision, 17
// stages of the restoring divider (one quotient bit each) and two stages for the
// cut point and output register. When the result port stalls, the whole pipeline
// holds. Register writes are taken in any cycle and must only be made while
// no segment is in flight.
`include "segment_plane_clip_assert.svh"

module segment_plane_clip (
    input  logic       clk,
    input  logic       rst_n,
    spc_seg_in_if.sink  seg_in,
    spc_seg_out_if.source seg_out,
    spc_cfg_if.sink     cfg
);
    import spc_pkg::*;

    plane_t              plane_reg;
    logic                en;
    vec3_t               s, e, kept_s, kept_e;
    logic                d_valid, q_valid, o_valid, o_trim;
    logic [DOT_W-1:0]    an, ad;
    logic [Q_W-1:0]      t;
    logic [1:0]          o_code;
    seg_info_t           d_info, q_info;

    // register writes
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg.point  <= '0;
            plane_reg.normal <= {COORD_BITS'(1) << FRAC_BITS, {(2*COORD_BITS){1'b0}}};
            plane_reg.tol    <= TOL_BITS'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_POINT_X:  plane_reg.point[0]  <= cfg.data;
                REG_POINT_Y:  plane_reg.point[1]  <= cfg.data;
                REG_POINT_Z:  plane_reg.point[2]  <= cfg.data;
                REG_NORMAL_X: plane_reg.normal[0] <= cfg.data;
                REG_NORMAL_Y: plane_reg.normal[1] <= cfg.data;
                REG_NORMAL_Z: plane_reg.normal[2] <= cfg.data;
                REG_TOL:      plane_reg.tol       <= cfg.data[TOL_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // single advance for all stages
    assign en = !o_valid || seg_out.ready;
    assign seg_in.ready = en;

    assign s = {seg_in.start_z, seg_in.start_y, seg_in.start_x};
    assign e = {seg_in.end_z, seg_in.end_y, seg_in.end_x};

    spc_dot u_dot (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(seg_in.valid),
        .s(s), .e(e), .plane(plane_reg),
        .out_valid(d_valid), .an(an), .ad(ad), .info(d_info)
    );

    spc_div u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(d_valid),
        .an(an), .ad(ad), .in_info(d_info),
        .out_valid(q_valid), .t(t), .out_info(q_info)
    );

    spc_cut u_cut (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(q_valid),
        .t(t), .in_info(q_info),
        .out_valid(o_valid), .kept_s(kept_s), .kept_e(kept_e),
        .trimmed(o_trim), .code(o_code)
    );

    assign seg_out.valid         = o_valid;
    assign seg_out.kept_start_x  = kept_s[0];
    assign seg_out.kept_start_y  = kept_s[1];
    assign seg_out.kept_start_z  = kept_s[2];
    assign seg_out.kept_end_x    = kept_e[0];
    assign seg_out.kept_end_y    = kept_e[1];
    assign seg_out.kept_end_z    = kept_e[2];
    assign seg_out.fully_trimmed = o_trim;
    assign seg_out.case_code     = o_code;

    // checks
    `SPC_ASSERT_IMP(a_trim_zero, seg_out.valid && seg_out.fully_trimmed, kept_s == '0 && kept_e == '0, "trimmed word with nonzero ends")
    `SPC_ASSERT_IMP(a_keep_codes, seg_out.valid && (seg_out.case_code == CASE_CUT || seg_out.case_code == CASE_COINCIDENT), !seg_out.fully_trimmed, "cut or coincident word marked trimmed")
    `SPC_ASSERT_IMP(a_stall_hold, seg_out.valid && !seg_out.ready, !seg_in.ready, "segment taken while result stalled")

endmodule

// ===== src/spc_dot.sv =====
// Front stages: offsets, dot products with the normal and case decision.
module spc_dot (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  spc_pkg::vec3_t                s,
    input  spc_pkg::vec3_t                e,
    input  spc_pkg::plane_t               plane,
    output logic                          out_valid,
    output logic [spc_pkg::DOT_W-1:0]     an,
    output logic [spc_pkg::DOT_W-1:0]     ad,
    output spc_pkg::seg_info_t            info
);
    import spc_pkg::*;

    logic                  a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    vec3_t                 a_s_reg, a_e_reg, b_s_reg, b_e_reg, c_s_reg, c_e_reg;
    vec3_t                 a_off_reg, a_dir_reg;
    logic [2:0][PROD_W-1:0] b_poff_reg, b_pdir_reg;
    logic [DOT_W-1:0]      c_num_reg, c_den_reg;
    logic [DOT_W-1:0]      d_an_reg, d_ad_reg;
    seg_info_t             d_info_reg;
    logic [DOT_W-1:0]      num_next, den_next, an_next, ad_next, tol_ext;
    seg_info_t             info_next;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // stage A: saturated offset and direction; B: component products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s_reg <= s;
            a_e_reg <= e;
            for (int i = 0; i < 3; i++)
            begin
                a_off_reg[i] <= sat_coord(coord_diff(plane.point[i], s[i]));
                a_dir_reg[i] <= sat_coord(coord_diff(e[i], s[i]));
                b_poff_reg[i] <= PROD_W'($signed(a_off_reg[i]) * $signed(plane.normal[i]));
                b_pdir_reg[i] <= PROD_W'($signed(a_dir_reg[i]) * $signed(plane.normal[i]));
            end
            b_s_reg <= a_s_reg;
            b_e_reg <= a_e_reg;
            c_s_reg <= b_s_reg;
            c_e_reg <= b_e_reg;
            c_num_reg <= num_next;
            c_den_reg <= den_next;
            d_an_reg <= an_next;
            d_ad_reg <= ad_next;
            d_info_reg <= info_next;
        end
    end

    // stage C: floor-shift each product to Q16.16 and sum
    always_comb
    begin
        num_next = '0;
        den_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            num_next = num_next + {{2{b_poff_reg[i][PROD_W-1]}},
                                   b_poff_reg[i][PROD_W-1:FRAC_BITS]};
            den_next = den_next + {{2{b_pdir_reg[i][PROD_W-1]}},
                                   b_pdir_reg[i][PROD_W-1:FRAC_BITS]};
        end
    end

    // stage D: magnitudes and case decision
    always_comb
    begin
        an_next = c_num_reg[DOT_W-1] ? -c_num_reg : c_num_reg;
        ad_next = c_den_reg[DOT_W-1] ? -c_den_reg : c_den_reg;
        tol_ext = {{(DOT_W-TOL_BITS){1'b0}}, plane.tol};
        info_next.s = c_s_reg;
        info_next.e = c_e_reg;
        info_next.whole = 1'b1;
        info_next.from_start = 1'b1;
        // side > 0 exactly when num < 0
        info_next.trimmed = 1'b0;
        if (c_den_reg == '0 || ad_next < tol_ext)
        begin
            if (an_next > tol_ext)
            begin
                info_next.code = CASE_PARALLEL;
                info_next.trimmed = c_num_reg[DOT_W-1];
            end
            else
                info_next.code = CASE_COINCIDENT;
        end
        else if ((c_num_reg != '0 && c_num_reg[DOT_W-1] != c_den_reg[DOT_W-1])
                 || an_next > ad_next)
        begin
            info_next.code = CASE_OUTSIDE;
            info_next.trimmed = c_num_reg[DOT_W-1];
        end
        else
        begin
            info_next.code = CASE_CUT;
            info_next.whole = 1'b0;
            info_next.from_start = !c_num_reg[DOT_W-1] && (c_num_reg != '0);
        end
    end

    assign out_valid = d_valid_reg;
    assign an = d_an_reg;
    assign ad = d_ad_reg;
    assign info = d_info_reg;

endmodule

// ===== src/spc_div.sv =====
// Pipelined restoring divider: t = an * 2^FRAC_BITS / ad, one quotient bit a stage.
module spc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [spc_pkg::DOT_W-1:0]     an,
    input  logic [spc_pkg::DOT_W-1:0]     ad,
    input  spc_pkg::seg_info_t            in_info,
    output logic                          out_valid,
    output logic [spc_pkg::Q_W-1:0]       t,
    output spc_pkg::seg_info_t            out_info
);
    import spc_pkg::*;

    logic [Q_W-1:0]             v_reg;
    logic [REM_W-1:0]           rem_reg [Q_W];
    logic [DOT_W-1:0]           ad_reg  [Q_W];
    logic [Q_W-1:0]             q_reg   [Q_W];
    seg_info_t                  info_reg [Q_W];

    genvar g;
    generate
        for (g = 0; g < Q_W; g++)
        begin : g_step
            logic [REM_W-1:0] r_src, r_diff;
            logic [DOT_W-1:0] ad_src;
            logic [Q_W-1:0]   q_src;
            seg_info_t        info_src;
            logic             v_src, bit_q;

            // first step takes the raw numerator, later ones double the remainder
            if (g == 0)
            begin : g_first
                assign r_src    = {1'b0, an};
                assign ad_src   = ad;
                assign q_src    = '0;
                assign info_src = in_info;
                assign v_src    = in_valid;
            end
            else
            begin : g_rest
                assign r_src    = {rem_reg[g-1][REM_W-2:0], 1'b0};
                assign ad_src   = ad_reg[g-1];
                assign q_src    = q_reg[g-1];
                assign info_src = info_reg[g-1];
                assign v_src    = v_reg[g-1];
            end

            assign r_diff = r_src - {1'b0, ad_src};
            assign bit_q  = !r_diff[REM_W-1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[g] <= 1'b0;
                else if (en)
                    v_reg[g] <= v_src;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g]  <= bit_q ? r_diff : r_src;
                    ad_reg[g]   <= ad_src;
                    q_reg[g]    <= {q_src[Q_W-2:0], bit_q};
                    info_reg[g] <= info_src;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[Q_W-1];
    assign t = q_reg[Q_W-1];
    assign out_info = info_reg[Q_W-1];

endmodule

// ===== src/spc_cut.sv =====
// Back stages: intersection point and selection of the kept piece.
module spc_cut (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [spc_pkg::Q_W-1:0]  t,
    input  spc_pkg::seg_info_t       in_info,
    output logic                     out_valid,
    output spc_pkg::vec3_t           kept_s,
    output spc_pkg::vec3_t           kept_e,
    output logic                     trimmed,
    output logic [1:0]               code
);
    import spc_pkg::*;

    logic                     e_valid_reg, f_valid_reg;
    logic [2:0][TPROD_W-1:0]  e_prod_reg;
    seg_info_t                e_info_reg;
    vec3_t                    f_ks_reg, f_ke_reg, cut, ks_next, ke_next;
    logic                     f_trim_reg;
    logic [1:0]               f_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= in_valid;
            f_valid_reg <= e_valid_reg;
        end
    end

    // stage E: t times exact direction
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                e_prod_reg[i] <= TPROD_W'($signed({1'b0, t})
                                 * $signed(coord_diff(in_info.e[i], in_info.s[i])));
            e_info_reg <= in_info;
        end
    end

    // stage F: add start, choose ends
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cut[i] = e_info_reg.s[i] + e_prod_reg[i][FRAC_BITS+COORD_BITS-1:FRAC_BITS];
            if (e_info_reg.trimmed)
            begin
                ks_next[i] = '0;
                ke_next[i] = '0;
            end
            else if (e_info_reg.whole)
            begin
                ks_next[i] = e_info_reg.s[i];
                ke_next[i] = e_info_reg.e[i];
            end
            else if (e_info_reg.from_start)
            begin
                ks_next[i] = e_info_reg.s[i];
                ke_next[i] = cut[i];
            end
            else
            begin
                ks_next[i] = cut[i];
                ke_next[i] = e_info_reg.e[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_ks_reg   <= ks_next;
            f_ke_reg   <= ke_next;
            f_trim_reg <= e_info_reg.trimmed;
            f_code_reg <= e_info_reg.code;
        end
    end

    assign out_valid = f_valid_reg;
    assign kept_s = f_ks_reg;
    assign kept_e = f_ke_reg;
    assign trimmed = f_trim_reg;
    assign code = f_code_reg;

endmodule

// ===== tb/sv/spc_clip_checker.sv =====
// Checker for the segment plane clipper: predicts each result word and compares it.
`timescale 1ns / 1ps

module spc_clip_checker (
    input  logic           clk,
    input  logic           rst_n,
    spc_seg_in_if.monitor  seg_mon,
    spc_seg_out_if.monitor res_mon,
    spc_cfg_if.monitor     cfg_mon,
    output int             fail_count,
    output int             pending
);
    import spc_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] ksx, ksy, ksz, kex, key, kez;
        logic                  trimmed;
        logic [1:0]            code;
    } clip_res_t;

    // shadow register file
    logic signed [63:0] pt [3];
    logic signed [63:0] nrm [3];
    logic [63:0]        tol;

    clip_res_t clip_q[$];

    function automatic logic signed [63:0] floor_shift(logic signed [127:0] x);
        floor_shift = 64'(x >>> FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] x);
        if (x > 64'sd2147483647) clamp32 = 64'sd2147483647;
        else if (x < -64'sd2147483648) clamp32 = -64'sd2147483648;
        else clamp32 = x;
    endfunction

    function automatic clip_res_t clip_segment(logic signed [63:0] s [3],
                                               logic signed [63:0] e [3]);
        logic signed [63:0] dir [3];
        logic signed [63:0] cutp [3];
        logic signed [63:0] num, den, side, an, ad;
        logic signed [127:0] acc_n, acc_d;
        logic [127:0] tq;
        logic [1:0] code;
        logic trimmed, whole, from_start;
        logic signed [63:0] a [3];
        logic signed [63:0] b [3];
        clip_res_t r;
        trimmed = 0; whole = 1; from_start = 1;
        num = 0; den = 0;
        for (int i = 0; i < 3; i++)
        begin
            dir[i] = e[i] - s[i];
            cutp[i] = 0;
            acc_n = 128'(clamp32(pt[i] - s[i])) * 128'(nrm[i]);
            acc_d = 128'(clamp32(dir[i])) * 128'(nrm[i]);
            num += floor_shift(acc_n);
            den += floor_shift(acc_d);
        end
        side = -num;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        if (den == 0 || ad < $signed(tol))
        begin
            if (an > $signed(tol))
            begin
                code = CASE_PARALLEL;
                trimmed = side > 0;
            end
            else
                code = CASE_COINCIDENT;
        end
        else if ((num != 0 && ((num < 0) != (den < 0))) || an > ad)
        begin
            code = CASE_OUTSIDE;
            trimmed = side > 0;
        end
        else
        begin
            code = CASE_CUT;
            whole = 0;
            tq = (128'(an) << FRAC_BITS) / 128'(ad);
            for (int i = 0; i < 3; i++)
                cutp[i] = s[i] + floor_shift($signed(tq) * 128'(dir[i]));
            from_start = side < 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            a[i] = 0; b[i] = 0;
            if (!trimmed)
            begin
                if (whole) begin a[i] = s[i]; b[i] = e[i]; end
                else if (from_start) begin a[i] = s[i]; b[i] = cutp[i]; end
                else begin a[i] = cutp[i]; b[i] = e[i]; end
            end
        end
        r.ksx = a[0][31:0]; r.ksy = a[1][31:0]; r.ksz = a[2][31:0];
        r.kex = b[0][31:0]; r.key = b[1][31:0]; r.kez = b[2][31:0];
        r.trimmed = trimmed;
        r.code = code;
        return r;
    endfunction

    assign pending = clip_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic signed [63:0] s [3];
        logic signed [63:0] e [3];
        clip_res_t got, want;
        if (!rst_n)
        begin
            pt[0] = 0; pt[1] = 0; pt[2] = 0;
            nrm[0] = 0; nrm[1] = 0; nrm[2] = 65536;
            tol = 1;
            clip_q.delete();
            fail_count = 0;
        end
        else
        begin
            // register writes
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    REG_POINT_X:  pt[0]  = $signed(cfg_mon.data);
                    REG_POINT_Y:  pt[1]  = $signed(cfg_mon.data);
                    REG_POINT_Z:  pt[2]  = $signed(cfg_mon.data);
                    REG_NORMAL_X: nrm[0] = $signed(cfg_mon.data);
                    REG_NORMAL_Y: nrm[1] = $signed(cfg_mon.data);
                    REG_NORMAL_Z: nrm[2] = $signed(cfg_mon.data);
                    REG_TOL:      tol    = 64'(cfg_mon.data[TOL_BITS-1:0]);
                    default: ;
                endcase
            end
            // result words
            if (res_mon.valid && res_mon.ready)
            begin
                got = {res_mon.kept_start_x, res_mon.kept_start_y, res_mon.kept_start_z,
                       res_mon.kept_end_x, res_mon.kept_end_y, res_mon.kept_end_z,
                       res_mon.fully_trimmed, res_mon.case_code};
                if (clip_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result word %h", got);
                end
                else
                begin
                    want = clip_q.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %h actual %h", want, got);
                    end
                end
            end
            // segment words
            if (seg_mon.valid && seg_mon.ready)
            begin
                s[0] = seg_mon.start_x; s[1] = seg_mon.start_y; s[2] = seg_mon.start_z;
                e[0] = seg_mon.end_x;   e[1] = seg_mon.end_y;   e[2] = seg_mon.end_z;
                clip_q.insert(clip_q.size(), clip_segment(s, e));
            end
        end
    end
endmodule

// ===== tb/sv/tb_segment_plane_clip.sv =====
// Testbench top for the segment plane clipper: stimulus, register phases and verdict.
`timescale 1ns / 1ps

module tb_segment_plane_clip;
    import spc_pkg::*;

    localparam int LIMIT = 200000;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycles;
    bit   calm;

    spc_seg_in_if  seg_in();
    spc_seg_out_if seg_out();
    spc_cfg_if     cfg();

    segment_plane_clip uut (.clk(clk), .rst_n(rst_n), .seg_in(seg_in),
                            .seg_out(seg_out), .cfg(cfg));

    spc_clip_checker chk (.clk(clk), .rst_n(rst_n), .seg_mon(seg_in), .res_mon(seg_out),
                          .cfg_mon(cfg), .fail_count(fail_count), .pending(pending));

    always
    begin
        clk = 1'b1; #2;
        clk = 1'b0; #2;
    end

    // timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAIL segment_plane_clip");
            $finish;
        end
    end

    // result side stalls in bursts
    always @(negedge clk)
    begin
        int burst;
        if (!rst_n || calm) seg_out.ready <= 1'b1;
        else if (burst > 0) begin burst--; seg_out.ready <= 1'b0; end
        else if ($urandom_range(0, 4) == 0)
        begin
            burst = $urandom_range(0, 2);
            seg_out.ready <= 1'b0;
        end
        else seg_out.ready <= 1'b1;
    end

    // valid stays high across back-to-back writes; the caller drops it
    task automatic write_reg(logic [IDX_BITS-1:0] idx, logic [COORD_BITS-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_seg(logic [5:0][31:0] c);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            seg_in.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        seg_in.valid <= 1'b1;
        {seg_in.start_x, seg_in.start_y, seg_in.start_z,
         seg_in.end_x, seg_in.end_y, seg_in.end_z} <= c;
        @(posedge clk);
        while (!seg_in.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        seg_in.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic logic [31:0] rcoord(int mode);
        case (mode)
            0: rcoord = $urandom();
            1: rcoord = 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
            2: rcoord = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: rcoord = 32'($signed($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    task automatic plane_phase(int kind);
        logic [31:0] v;
        for (int i = 0; i < 6; i++)
        begin
            case (kind)
                0: v = $urandom();
                1: v = (i < 3) ? rcoord(1) : rcoord(1);
                2: v = (i % 2) ? 32'h7fffffff : 32'h80000000;
                default: v = (i < 3) ? 32'h0 : ((i == 5) ? 32'h00010000 : 32'h0);
            endcase
            write_reg(IDX_BITS'(i), v);
        end
        case (kind)
            2: write_reg(REG_TOL, 32'h10000);
            3: write_reg(REG_TOL, 32'h0);
            default: write_reg(REG_TOL, $urandom_range(0, 65536));
        endcase
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        logic [5:0][31:0] c;
        logic [31:0] a;
        int mode;
        cycles = 0;
        calm = 0;
        rst_n = 1'b0;
        seg_in.valid = 1'b0;
        seg_in.start_x = 0; seg_in.start_y = 0; seg_in.start_z = 0;
        seg_in.end_x = 0; seg_in.end_y = 0; seg_in.end_z = 0;
        cfg.valid = 1'b0; cfg.index = 0; cfg.data = 0;
        seg_out.ready = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset plane z = 0, normal +z
        send_seg({32'h0, 32'h0, 32'hffff0000, 32'h0, 32'h0, 32'h00010000}); // cut
        send_seg({32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0, 32'hffff0000}); // cut reverse
        send_seg({32'h0, 32'h0, 32'h00020000, 32'h0, 32'h0, 32'h00050000}); // outside, trimmed
        send_seg({32'h0, 32'h0, 32'hfffe0000, 32'h0, 32'h0, 32'hfff00000}); // outside, kept
        send_seg({32'h0, 32'h0, 32'h00030000, 32'h00010000, 32'h0, 32'h00030000}); // parallel
        send_seg({32'h0, 32'h0, 32'hfffd0000, 32'h00010000, 32'h0, 32'hfffd0000});
        send_seg({32'h0, 32'h0, 32'h0, 32'h00010000, 32'h0, 32'h0}); // coincident
        send_seg({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}); // degenerate
        send_seg({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h00010000}); // t = 0
        send_seg({32'h0, 32'h0, 32'hffff0000, 32'h0, 32'h0, 32'h0}); // t = 1
        send_seg({32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
        send_seg({32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000});
        send_seg({32'hffffffff, 32'h0, 32'hffffffff, 32'h1, 32'h0, 32'h1});
        drain();

        // random phases through several planes
        for (int ph = 0; ph < 8; ph++)
        begin
            plane_phase(ph % 4);
            for (int k = 0; k < 50; k++)
            begin
                if (ph == 7 && k >= 30) calm = 1;
                mode = $urandom_range(0, 3);
                for (int j = 0; j < 6; j++) c[j] = rcoord(mode);
                // in the z = 0 plane phases, mostly segments across the plane so cuts happen
                if (ph % 4 == 3 && $urandom_range(0, 2) != 0)
                begin
                    a = rcoord(1);
                    c[3] = a;
                    c[0] = 32'($signed(-$signed(a)) + $signed($urandom_range(0, 255)));
                end
                send_seg(c);
            end
            drain();
        end

        if (fail_count == 0)
            $display("PASS segment_plane_clip");
        else
            $display("FAIL segment_plane_clip");
        $finish;
    end
endmodule
